>>> rtl/q2m_pkg.sv
`default_nettype none
package q2m_pkg;
    localparam int NUM_W     = 34;
    localparam int QUOT_W    = 17;
    localparam int ENTRIES   = 9;
    localparam int STEP_CW   = 5;
    localparam logic signed [31:0] FX_ONE = 32'sd65536;

    typedef logic signed [NUM_W-1:0] t_num;

    typedef struct packed {
        logic [NUM_W-1:0]               norm;
        logic [ENTRIES-1:0][NUM_W-1:0]  num;
        logic signed [31:0]             tx;
        logic signed [31:0]             ty;
        logic signed [31:0]             tz;
        logic                           zq;
    } t_job;
endpackage
`default_nettype wire

>>> rtl/q2m_fifo.sv
`default_nettype none
module q2m_fifo (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_wr,
    input  q2m_pkg::t_job      i_data,
    output logic               o_full,
    input  wire logic          i_rd,
    output logic               o_empty,
    output q2m_pkg::t_job      o_data
);
    import q2m_pkg::*;

    t_job       r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (i_wr && !o_full) begin
            r_mem[r_wp] <= i_data;
        end
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_wr && !o_full) r_wp <= ~r_wp;
            if (i_rd && !o_empty) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, (i_wr && !o_full)} - {1'b0, (i_rd && !o_empty)};
        end
    end
endmodule
`default_nettype wire

>>> rtl/q2m_front.sv
`default_nettype none
module q2m_front (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push,
    output logic                    o_full,
    input  wire logic signed [15:0] i_w,
    input  wire logic signed [15:0] i_x,
    input  wire logic signed [15:0] i_y,
    input  wire logic signed [15:0] i_z,
    input  wire logic signed [31:0] i_tx,
    input  wire logic signed [31:0] i_ty,
    input  wire logic signed [31:0] i_tz,
    output logic                    o_wr,
    input  wire logic               i_q_full,
    output q2m_pkg::t_job           o_job
);
    import q2m_pkg::*;

    logic               r_v;
    logic signed [31:0] r_ww, r_xx, r_yy, r_zz, r_xy, r_wz, r_xz, r_wy, r_yz, r_wx;
    logic signed [31:0] r_tx, r_ty, r_tz;
    logic               take;
    t_num               n, a_xy_wz, s_xy_wz, a_xz_wy, s_xz_wy, a_yz_wx, s_yz_wx;

    assign o_full = r_v && i_q_full;
    assign take   = i_push && !o_full;
    assign o_wr   = r_v && !i_q_full;

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_ww <= i_w * i_w;
            r_xx <= i_x * i_x;
            r_yy <= i_y * i_y;
            r_zz <= i_z * i_z;
            r_xy <= i_x * i_y;
            r_wz <= i_w * i_z;
            r_xz <= i_x * i_z;
            r_wy <= i_w * i_y;
            r_yz <= i_y * i_z;
            r_wx <= i_w * i_x;
            r_tx <= i_tx;
            r_ty <= i_ty;
            r_tz <= i_tz;
        end
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (take) begin
            r_v <= 1'b1;
        end else if (o_wr) begin
            r_v <= 1'b0;
        end
    end

    always_comb begin
        n       = t_num'(r_ww) + t_num'(r_xx) + t_num'(r_yy) + t_num'(r_zz);
        a_xy_wz = (t_num'(r_xy) + t_num'(r_wz)) <<< 1;
        s_xy_wz = (t_num'(r_xy) - t_num'(r_wz)) <<< 1;
        a_xz_wy = (t_num'(r_xz) + t_num'(r_wy)) <<< 1;
        s_xz_wy = (t_num'(r_xz) - t_num'(r_wy)) <<< 1;
        a_yz_wx = (t_num'(r_yz) + t_num'(r_wx)) <<< 1;
        s_yz_wx = (t_num'(r_yz) - t_num'(r_wx)) <<< 1;
        o_job.norm   = n;
        o_job.num[0] = n - ((t_num'(r_yy) + t_num'(r_zz)) <<< 1);
        o_job.num[1] = s_xy_wz;
        o_job.num[2] = a_xz_wy;
        o_job.num[3] = a_xy_wz;
        o_job.num[4] = n - ((t_num'(r_xx) + t_num'(r_zz)) <<< 1);
        o_job.num[5] = s_yz_wx;
        o_job.num[6] = s_xz_wy;
        o_job.num[7] = a_yz_wx;
        o_job.num[8] = n - ((t_num'(r_xx) + t_num'(r_yy)) <<< 1);
        o_job.tx     = r_tx;
        o_job.ty     = r_ty;
        o_job.tz     = r_tz;
        o_job.zq     = (n == '0);
    end
endmodule
`default_nettype wire

>>> rtl/q2m_div.sv
`default_nettype none
module q2m_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_load,
    input  wire logic                        i_step,
    input  wire logic [q2m_pkg::NUM_W-1:0]   i_num,
    input  wire logic [q2m_pkg::NUM_W-1:0]   i_norm,
    output logic signed [31:0]               o_quot
);
    import q2m_pkg::*;

    logic [NUM_W-1:0]  r_rem, r_n, mag, t;
    logic [QUOT_W-1:0] r_low, r_q;
    logic              r_neg;
    logic [48:0]       dvd;

    // dividend = |num| * 2^16 + n/2, quotient fits 17 bits
    always_comb begin
        mag = i_num[NUM_W-1] ? (~i_num + 1'b1) : i_num;
        dvd = {mag[32:0], 16'd0} + {17'd0, i_norm[32:1]};
        t   = {r_rem[NUM_W-2:0], r_low[QUOT_W-1]};
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_rem <= {2'b00, dvd[48:17]};
            r_low <= dvd[16:0];
            r_q   <= '0;
            r_neg <= i_num[NUM_W-1];
            r_n   <= i_norm;
        end else if (i_step) begin
            r_low <= {r_low[QUOT_W-2:0], 1'b0};
            if (t >= r_n) begin
                r_rem <= t - r_n;
                r_q   <= {r_q[QUOT_W-2:0], 1'b1};
            end else begin
                r_rem <= t;
                r_q   <= {r_q[QUOT_W-2:0], 1'b0};
            end
        end
    end

    assign o_quot = r_neg ? -$signed({15'd0, r_q}) : $signed({15'd0, r_q});
endmodule
`default_nettype wire

>>> rtl/q2m_back.sv
`default_nettype none
module q2m_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_gl,
    input  wire logic          i_q_empty,
    input  q2m_pkg::t_job      i_job,
    output logic               o_rd,
    output logic               o_empty,
    input  wire logic          i_pop,
    output logic [1:0]         o_row,
    output logic signed [31:0] o_c0,
    output logic signed [31:0] o_c1,
    output logic signed [31:0] o_c2,
    output logic signed [31:0] o_c3,
    output logic               o_last,
    output logic               o_zq
);
    import q2m_pkg::*;

    typedef enum logic [1:0] {S_IDLE, S_DIV, S_OUT} t_state;

    t_state              r_state;
    logic [STEP_CW-1:0]  r_cnt;
    logic [1:0]          r_row;
    logic signed [31:0]  r_tx, r_ty, r_tz;
    logic                r_zq;
    logic signed [31:0]  quot [ENTRIES];
    logic signed [31:0]  ent  [3][3];
    logic signed [31:0]  tsel;
    logic                step;

    assign o_rd = (r_state == S_IDLE) && !i_q_empty;
    assign step = (r_state == S_DIV);

    for (genvar k = 0; k < ENTRIES; k++) begin : g_lane
        q2m_div u_div (
            .i_clk  (i_clk),
            .i_load (o_rd),
            .i_step (step),
            .i_num  (i_job.num[k]),
            .i_norm (i_job.norm),
            .o_quot (quot[k])
        );
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++) begin
                if (r_zq) ent[i][j] = (i == j) ? FX_ONE : 32'sd0;
                else if (i_gl) ent[i][j] = quot[j*3+i];
                else ent[i][j] = quot[i*3+j];
            end
        end
        case (r_row)
            2'd0:    tsel = r_tx;
            2'd1:    tsel = r_ty;
            2'd2:    tsel = r_tz;
            default: tsel = '0;
        endcase
        o_empty = (r_state != S_OUT);
        o_row   = r_row;
        o_last  = (r_row == 2'd3);
        o_zq    = r_zq;
        if (r_row == 2'd3) begin
            o_c0 = i_gl ? r_tx : 32'sd0;
            o_c1 = i_gl ? r_ty : 32'sd0;
            o_c2 = i_gl ? r_tz : 32'sd0;
            o_c3 = FX_ONE;
        end else begin
            o_c0 = ent[r_row][0];
            o_c1 = ent[r_row][1];
            o_c2 = ent[r_row][2];
            o_c3 = i_gl ? 32'sd0 : tsel;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rd) begin
            r_tx <= i_job.tx;
            r_ty <= i_job.ty;
            r_tz <= i_job.tz;
            r_zq <= i_job.zq;
        end
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_row   <= 2'd0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (!i_q_empty) begin
                        r_state <= S_DIV;
                        r_cnt   <= '0;
                    end
                end
                S_DIV: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == STEP_CW'(QUOT_W - 1)) begin
                        r_state <= S_OUT;
                        r_row   <= 2'd0;
                    end
                end
                S_OUT: begin
                    if (i_pop) begin
                        r_row <= r_row + 1'b1;
                        if (r_row == 2'd3) r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

>>> rtl/quaternion_to_matrix.sv
// Quaternion plus translation to 4x4 homogeneous matrix, Q16.16 entries.
// Input queue side: drive the seven fields with push; a transfer happens
// on a clock edge with push high and full low. Result queue side: while
// empty is low the current row is on the o_ ports; pop high at a clock
// edge with empty low transfers it. Each item gives four rows, 0 to 3,
// with o_last_row on row 3 and o_zero_quat on all rows of a zero quaternion.
// i_cfg_we/i_cfg_data write gl_layout (bit 0); write it only while idle.
// Front: registered 16x16 products, then a two-entry job queue.
// Back: nine divider lanes, one quotient bit per cycle in a 17-step
// division, then four rows out, one row per cycle while pop is high.
// The back loads a job from the job queue only when idle, that is once
// all four rows of its last job have been popped.
// When the result side stalls, queue and front register fill; full rises.
// Reset clears both queues and gl_layout.
`default_nettype none
module quaternion_to_matrix (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               push,
    output logic                    full,
    input  wire logic signed [15:0] i_quat_w,
    input  wire logic signed [15:0] i_quat_x,
    input  wire logic signed [15:0] i_quat_y,
    input  wire logic signed [15:0] i_quat_z,
    input  wire logic signed [31:0] i_trans_x,
    input  wire logic signed [31:0] i_trans_y,
    input  wire logic signed [31:0] i_trans_z,
    output logic                    empty,
    input  wire logic               pop,
    output logic [1:0]              o_row_index,
    output logic signed [31:0]      o_col_zero,
    output logic signed [31:0]      o_col_one,
    output logic signed [31:0]      o_col_two,
    output logic signed [31:0]      o_col_three,
    output logic                    o_last_row,
    output logic                    o_zero_quat,
    input  wire logic               i_cfg_we,
    input  wire logic               i_cfg_data
);
    import q2m_pkg::*;

    logic r_gl;
    logic q_wr, q_rd, q_full, q_empty;
    t_job f_job, b_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gl <= 1'b0;
        end else if (i_cfg_we) begin
            r_gl <= i_cfg_data;
        end
    end

    q2m_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .o_full   (full),
        .i_w      (i_quat_w),
        .i_x      (i_quat_x),
        .i_y      (i_quat_y),
        .i_z      (i_quat_z),
        .i_tx     (i_trans_x),
        .i_ty     (i_trans_y),
        .i_tz     (i_trans_z),
        .o_wr     (q_wr),
        .i_q_full (q_full),
        .o_job    (f_job)
    );

    q2m_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_data  (f_job),
        .o_full  (q_full),
        .i_rd    (q_rd),
        .o_empty (q_empty),
        .o_data  (b_job)
    );

    q2m_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_gl      (r_gl),
        .i_q_empty (q_empty),
        .i_job     (b_job),
        .o_rd      (q_rd),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_row     (o_row_index),
        .o_c0      (o_col_zero),
        .o_c1      (o_col_one),
        .o_c2      (o_col_two),
        .o_c3      (o_col_three),
        .o_last    (o_last_row),
        .o_zq      (o_zero_quat)
    );
endmodule
`default_nettype wire

>>> rtl/q2m_checker.sv
`default_nettype none
module q2m_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       empty,
    input wire logic       pop,
    input wire logic [1:0] o_row_index,
    input wire logic       o_last_row,
    input wire logic       o_zero_quat
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("results present after reset");

    a_last_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty |-> (o_last_row == (o_row_index == 2'd3)))
        else $error("last row flag mismatch");

    a_row_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_row) |=>
            (!empty && o_row_index == $past(o_row_index) + 2'd1))
        else $error("row sequence broken");

    a_zq_same: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && !o_last_row) |=> (o_zero_quat == $past(o_zero_quat)))
        else $error("zero flag changed within matrix");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && !pop) |=> (!empty && $stable(o_row_index)))
        else $error("stalled result changed");
endmodule

bind quaternion_to_matrix q2m_checker u_q2m_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .empty       (empty),
    .pop         (pop),
    .o_row_index (o_row_index),
    .o_last_row  (o_last_row),
    .o_zero_quat (o_zero_quat)
);
`default_nettype wire

>>> tb/tb_quaternion_to_matrix.sv
`timescale 1ns / 1ps
module tb_quaternion_to_matrix;

    localparam int HOLD_OFF_CYCLES = 400;
    localparam int TAIL_CYCLES     = 60;
    localparam longint CYCLE_LIMIT = 400000;
    localparam logic signed [31:0] ONE_FX = 32'sd65536;

    typedef struct {
        logic signed [15:0] w, x, y, z;
        logic signed [31:0] tx, ty, tz;
    } pose_t;

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] c0, c1, c2, c3;
        logic               last;
        logic               zq;
    } row_t;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic push = 1'b0;
    logic pop = 1'b0;
    logic full, empty;
    logic signed [15:0] i_quat_w = '0, i_quat_x = '0, i_quat_y = '0, i_quat_z = '0;
    logic signed [31:0] i_trans_x = '0, i_trans_y = '0, i_trans_z = '0;
    logic [1:0] o_row_index;
    logic signed [31:0] o_col_zero, o_col_one, o_col_two, o_col_three;
    logic o_last_row, o_zero_quat;
    logic i_cfg_we = 1'b0;
    logic i_cfg_data = 1'b0;

    pose_t pending_poses[$];
    row_t  expected_rows[$];
    logic  gl_mode = 1'b0;
    int    errors = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    hold_off_req = 0;
    int    hold_off_left = 0;
    longint cycles = 0;

    quaternion_to_matrix i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .push(push), .full(full),
        .i_quat_w(i_quat_w), .i_quat_x(i_quat_x), .i_quat_y(i_quat_y),
        .i_quat_z(i_quat_z), .i_trans_x(i_trans_x), .i_trans_y(i_trans_y),
        .i_trans_z(i_trans_z), .empty(empty), .pop(pop),
        .o_row_index(o_row_index), .o_col_zero(o_col_zero), .o_col_one(o_col_one),
        .o_col_two(o_col_two), .o_col_three(o_col_three), .o_last_row(o_last_row),
        .o_zero_quat(o_zero_quat), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // round(num * 65536 / n), ties away from zero
    function automatic logic signed [31:0] fx_quot(longint num, longint n);
        longint a, h;
        a = num * 65536;
        h = n / 2;
        if (a >= 0) begin
            return 32'((a + h) / n);
        end
        return 32'(-((-a + h) / n));
    endfunction

    task automatic predict_rows(input pose_t p);
        longint w, x, y, z, n;
        logic signed [31:0] r[3][3];
        logic signed [31:0] m[4][4];
        logic signed [31:0] t[3];
        row_t e;
        bit zq;
        w = p.w; x = p.x; y = p.y; z = p.z;
        n = w*w + x*x + y*y + z*z;
        zq = (n == 0);
        t[0] = p.tx; t[1] = p.ty; t[2] = p.tz;
        if (zq) begin
            for (int i = 0; i < 3; i++)
                for (int j = 0; j < 3; j++)
                    r[i][j] = (i == j) ? ONE_FX : 32'sd0;
        end else begin
            r[0][0] = fx_quot(n - 2*(y*y + z*z), n);
            r[0][1] = fx_quot(2*(x*y - w*z), n);
            r[0][2] = fx_quot(2*(x*z + w*y), n);
            r[1][0] = fx_quot(2*(x*y + w*z), n);
            r[1][1] = fx_quot(n - 2*(x*x + z*z), n);
            r[1][2] = fx_quot(2*(y*z - w*x), n);
            r[2][0] = fx_quot(2*(x*z - w*y), n);
            r[2][1] = fx_quot(2*(y*z + w*x), n);
            r[2][2] = fx_quot(n - 2*(x*x + y*y), n);
        end
        for (int i = 0; i < 3; i++) begin
            for (int j = 0; j < 3; j++)
                m[i][j] = gl_mode ? r[j][i] : r[i][j];
            m[i][3] = gl_mode ? 32'sd0 : t[i];
            m[3][i] = gl_mode ? t[i] : 32'sd0;
        end
        m[3][3] = ONE_FX;
        for (int i = 0; i < 4; i++) begin
            e.row = 2'(i);
            e.c0 = m[i][0]; e.c1 = m[i][1]; e.c2 = m[i][2]; e.c3 = m[i][3];
            e.last = (i == 3);
            e.zq = zq;
            expected_rows.push_back(e);
        end
    endtask

    // driver
    always @(posedge i_clk) begin
        pose_t p;
        if (i_rst_n) begin
            if (push && !full) begin
                predict_rows(pending_poses.pop_front());
            end
            if ((!push || !full) && pending_poses.size() > 0
                    && $urandom_range(99) >= send_idle_pct) begin
                p = pending_poses[0];
                push <= 1'b1;
                i_quat_w <= p.w; i_quat_x <= p.x; i_quat_y <= p.y; i_quat_z <= p.z;
                i_trans_x <= p.tx; i_trans_y <= p.ty; i_trans_z <= p.tz;
            end else if (!push || !full) begin
                push <= 1'b0;
            end
        end
    end

    // long receiver hold-off
    always @(posedge i_clk) begin
        if (hold_off_req && hold_off_left == 0) begin
            hold_off_left <= HOLD_OFF_CYCLES;
            hold_off_req <= 0;
        end else if (hold_off_left > 0) begin
            hold_off_left <= hold_off_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        row_t e;
        cycles <= cycles + 1;
        if (i_rst_n) begin
            if (pop && !empty) begin
                if (expected_rows.size() == 0) begin
                    $display("%0t: unexpected row %0d", $time, o_row_index);
                    errors++;
                end else begin
                    e = expected_rows.pop_front();
                    if (o_row_index !== e.row || o_col_zero !== e.c0
                            || o_col_one !== e.c1 || o_col_two !== e.c2
                            || o_col_three !== e.c3 || o_last_row !== e.last
                            || o_zero_quat !== e.zq) begin
                        $display("%0t: mismatch exp row=%0d %0d %0d %0d %0d l=%0b z=%0b",
                            $time, e.row, e.c0, e.c1, e.c2, e.c3, e.last, e.zq);
                        $display("%0t:          got row=%0d %0d %0d %0d %0d l=%0b z=%0b",
                            $time, o_row_index, o_col_zero, o_col_one, o_col_two,
                            o_col_three, o_last_row, o_zero_quat);
                        errors++;
                    end
                end
            end
            if (hold_off_req || hold_off_left > 0) begin
                pop <= 1'b0;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (cycles > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic pose_t rand_pose();
        pose_t p;
        int k;
        k = $urandom_range(9);
        p.w = 16'($urandom); p.x = 16'($urandom);
        p.y = 16'($urandom); p.z = 16'($urandom);
        if (k < 3) begin
            p.w = $signed(16'($urandom_range(64))) - 16'sd32;
            p.x = $signed(16'($urandom_range(64))) - 16'sd32;
            p.y = $signed(16'($urandom_range(64))) - 16'sd32;
            p.z = $signed(16'($urandom_range(64))) - 16'sd32;
        end else if (k == 3) begin
            p.w = 16'sd16384; p.x = '0; p.y = '0; p.z = '0;
        end
        p.tx = $urandom; p.ty = $urandom; p.tz = $urandom;
        if (k == 4) begin
            p.tx = '0; p.ty = '0; p.tz = '0;
        end
        return p;
    endfunction

    function automatic pose_t mk(int w, int x, int y, int z, int tx, int ty, int tz);
        pose_t p;
        p.w = 16'(w); p.x = 16'(x); p.y = 16'(y); p.z = 16'(z);
        p.tx = tx; p.ty = ty; p.tz = tz;
        return p;
    endfunction

    task automatic run_phase(input int n_items, input int idle, input int stall,
                             input bit gl, input bit with_directed, input bit hold);
        while (expected_rows.size() > 0 || pending_poses.size() > 0 || push)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_data <= gl;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        gl_mode = gl;
        send_idle_pct = idle;
        recv_stall_pct = stall;
        if (with_directed) begin
            pending_poses.push_back(mk(16384, 0, 0, 0, 0, 0, 0));
            pending_poses.push_back(mk(0, 0, 0, 0, 65536, -65536, 12345));
            pending_poses.push_back(mk(-32768, -32768, -32768, -32768,
                                       32'h7fffffff, 32'h80000000, -1));
            pending_poses.push_back(mk(32767, 32767, 32767, 32767, 0, 0, 0));
            pending_poses.push_back(mk(0, 16384, 0, 0, 1, 2, 3));
            pending_poses.push_back(mk(0, 0, 16384, 0, -1, -2, -3));
            pending_poses.push_back(mk(0, 0, 0, -16384, 0, 0, 0));
            pending_poses.push_back(mk(1, 0, 0, 0, 0, 0, 0));
            pending_poses.push_back(mk(1, 1, 1, 0, 0, 0, 0));
            pending_poses.push_back(mk(11585, 11585, 0, 0, 100, 200, 300));
            pending_poses.push_back(mk(-32768, 32767, 0, 1, 32'h80000000,
                                       32'h7fffffff, 0));
            pending_poses.push_back(mk(3, -5, 7, -2, -1, -1, -1));
        end
        if (hold) hold_off_req = 1;
        for (int i = 0; i < n_items; i++)
            pending_poses.push_back(rand_pose());
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        run_phase(12, 0, 0, 1'b0, 1'b1, 1'b0);
        run_phase(20, 0, 0, 1'b0, 1'b0, 1'b1);
        run_phase(12, 0, 0, 1'b1, 1'b1, 1'b0);
        run_phase(20, 70, 0, 1'b1, 1'b0, 1'b0);
        run_phase(20, 0, 70, 1'b0, 1'b0, 1'b0);
        run_phase(20, 8, 8, 1'b1, 1'b0, 1'b0);
        while (expected_rows.size() > 0 || pending_poses.size() > 0 || push)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/q2m_pkg.sv
rtl/q2m_fifo.sv
rtl/q2m_front.sv
rtl/q2m_div.sv
rtl/q2m_back.sv
rtl/quaternion_to_matrix.sv
rtl/q2m_checker.sv
tb/tb_quaternion_to_matrix.sv
